>>> design/hcbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared constants, request codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int CODE_FIELD_W     = 32;
  localparam int CODE_LEN_FIELD_W = 6;
  localparam int TABLE_DEPTH      = 256;
  localparam int SYM_W            = 8;
  localparam int BYTE_W           = 8;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  typedef struct packed {
    logic capture;
    logic write_entry;
    logic start_flush;
    logic align;
    logic emit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_ge8;
    logic out_busy;
  } dp_status_t;

endpackage

>>> design/hcbp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying table loads, symbols to encode and flushes.
// ----------------------------------------------------------------------------
interface hcbp_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            req_type;
  logic [hcbp_pkg::SYM_W-1:0]            symbol;
  logic [hcbp_pkg::CODE_FIELD_W-1:0]     code_bits;
  logic [hcbp_pkg::CODE_LEN_FIELD_W-1:0] code_length;

  modport source (output valid, req_type, symbol, code_bits, code_length, input ready);
  modport sink (input valid, req_type, symbol, code_bits, code_length, output ready);
endinterface

>>> design/hcbp_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying packed output bytes.
// ----------------------------------------------------------------------------
interface hcbp_res_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::BYTE_W-1:0] out_byte;
  logic                        last_in_run;

  modport source (output valid, out_byte, last_in_run, input ready);
  modport sink (input valid, out_byte, last_in_run, output ready);
endinterface

>>> design/hcbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman packer controller
// Sequences table loads, code lookups, byte emission and flushes.
// ----------------------------------------------------------------------------
module hcbp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_req_type,
  output logic                   in_ready,
  input  hcbp_pkg::dp_status_t   status,
  output hcbp_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            hcbp_pkg::REQ_LOAD: begin
              cmd.write_entry = 1'b1;
            end
            hcbp_pkg::REQ_ENCODE: begin
              cmd.capture = 1'b1;
              state_next  = ST_LOOKUP;
            end
            hcbp_pkg::REQ_FLUSH: begin
              cmd.start_flush = 1'b1;
              state_next      = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd.align  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.cnt_ge8) begin
          cmd.emit = !status.out_busy;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_emit_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == ST_EMIT))
    else $error("emit outside emit state");

  a_lookup_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |=> (state == ST_EMIT))
    else $error("lookup not followed by emit");

  a_encode_goes_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_LOOKUP))
    else $error("encode beat did not start lookup");
`endif

endmodule

>>> design/hcbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman packer datapath
// Code table, bit accumulator, pending byte state and output register.
// ----------------------------------------------------------------------------
module hcbp_datapath #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hcbp_pkg::dp_cmd_t                     cmd,
  output hcbp_pkg::dp_status_t                  status,
  input  logic [hcbp_pkg::SYM_W-1:0]            symbol,
  input  logic [hcbp_pkg::CODE_FIELD_W-1:0]     code_bits,
  input  logic [hcbp_pkg::CODE_LEN_FIELD_W-1:0] code_length,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hcbp_pkg::BYTE_W-1:0]           out_byte,
  output logic                                  out_last
);

  localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::CODE_FIELD_W) ?
                          MAX_CODE_LEN : hcbp_pkg::CODE_FIELD_W;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int ENT_W  = CODE_W + LEN_W;
  localparam int BUF_W  = CODE_W + hcbp_pkg::BYTE_W;
  localparam int CNT_W  = $clog2(BUF_W + 1);

  logic [ENT_W-1:0]  mem [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::TABLE_DEPTH-1:0] vld;
  logic [ENT_W-1:0]  rd_q;
  logic              rd_vld_q;

  logic [BUF_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic [hcbp_pkg::BYTE_W-1:0] pending_byte;
  logic [2:0]        pending_count;

  logic [LEN_W-1:0]  wr_len;
  logic [CODE_W:0]   wr_mask;
  logic [CODE_W-1:0] wr_code;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [CNT_W-1:0]  sh;
  logic [BUF_W-1:0]  acc_aligned;

  // length clamp and mask of the loaded code
  always_comb begin
    if (code_length > hcbp_pkg::CODE_LEN_FIELD_W'(CODE_W)) begin
      wr_len = LEN_W'(CODE_W);
    end else begin
      wr_len = LEN_W'(code_length);
    end
    wr_mask = ((CODE_W + 1)'(1) << wr_len) - (CODE_W + 1)'(1);
    wr_code = code_bits[CODE_W-1:0] & wr_mask[CODE_W-1:0];
  end

  assign rd_code = rd_vld_q ? rd_q[ENT_W-1 -: CODE_W] : '0;
  assign rd_len  = rd_vld_q ? rd_q[LEN_W-1:0] : '0;
  assign sh      = CNT_W'(BUF_W) - CNT_W'(pending_count) - CNT_W'(rd_len);
  assign acc_aligned = {pending_byte, {CODE_W{1'b0}}} | (BUF_W'(rd_code) << sh);

  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[symbol] <= {wr_code, wr_len};
    end
    if (cmd.capture) begin
      rd_q <= mem[symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd.write_entry) begin
        vld[symbol] <= 1'b1;
      end
      if (cmd.capture) begin
        rd_vld_q <= vld[symbol];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      cnt           <= '0;
      pending_byte  <= '0;
      pending_count <= '0;
    end else begin
      if (cmd.align) begin
        acc <= acc_aligned;
        cnt <= CNT_W'(pending_count) + CNT_W'(rd_len);
      end else if (cmd.start_flush) begin
        acc <= BUF_W'({pending_byte,
                       hcbp_pkg::ASCII_ZERO + hcbp_pkg::BYTE_W'(pending_count)})
               << (BUF_W - 2 * hcbp_pkg::BYTE_W);
        cnt <= (pending_count != 3'd0) ? CNT_W'(2 * hcbp_pkg::BYTE_W) : '0;
      end else if (cmd.emit) begin
        acc <= acc << hcbp_pkg::BYTE_W;
        cnt <= cnt - CNT_W'(hcbp_pkg::BYTE_W);
      end
      if (cmd.finish) begin
        pending_byte  <= acc[BUF_W-1 -: hcbp_pkg::BYTE_W];
        pending_count <= cnt[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= acc[BUF_W-1 -: hcbp_pkg::BYTE_W];
      out_last <= (cnt < CNT_W'(2 * hcbp_pkg::BYTE_W));
    end
  end

  assign status.cnt_ge8  = (cnt >= CNT_W'(hcbp_pkg::BYTE_W));
  assign status.out_busy = out_valid && !out_ready;

`ifndef ASSERT_OFF
  a_emit_needs_byte: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (cnt >= CNT_W'(hcbp_pkg::BYTE_W)))
    else $error("emit with fewer than eight bits");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("emit overwrote a waiting beat");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(BUF_W))
    else $error("bit count beyond accumulator");

  a_flush_two_bytes: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_flush && (pending_count != 3'd0)) |=> (cnt == CNT_W'(2 * hcbp_pkg::BYTE_W)))
    else $error("flush did not queue two bytes");
`endif

endmodule

>>> design/huffman_code_bit_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer core
// Loads a 256-entry code table, packs symbol codes MSB first into bytes and
// flushes a padded partial byte followed by its ASCII bit count.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  req      in   valid/ready  req_type, symbol, code_bits, code_length
//  res      out  valid/ready  out_byte, last_in_run
//
//  Load writes one table entry; encode reads it, aligns the code and
//  emits up to 4 output bytes; flush emits the pending byte and count.
//  One request at a time, paced by the single output register and accumulator.
//  Reset clears the table valid bits and the pending byte at once.
//  A stalled result holds emission; new requests wait in the meantime.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input logic        clk,
  input logic        rst,
  hcbp_req_if.sink   req,
  hcbp_res_if.source res
);

  hcbp_pkg::dp_cmd_t    cmd;
  hcbp_pkg::dp_status_t status;

  hcbp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .status      (status),
    .cmd         (cmd)
  );

  hcbp_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .symbol      (req.symbol),
    .code_bits   (req.code_bits),
    .code_length (req.code_length),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_byte    (res.out_byte),
    .out_last    (res.last_in_run)
  );

endmodule
